@@ hdl/gwv_pkg.sv @@
// shared widths, codes and control types for the grouped weighted variance block
package gwv_pkg;

    localparam int KEY_W      = 32;
    localparam int VAL_IN_W   = 16;
    localparam int WEIGHT_W   = 24;
    localparam int VAR_W      = 38;
    localparam int CNT_OUT_W  = 24;
    localparam int STATUS_W   = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_DATA = 2'd1,
        ST_SINGLE  = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OPEN,
        S_ACC_A,
        S_ACC_B,
        S_ACC_C,
        S_ACC_D,
        S_CHK,
        S_MUL_S2,
        S_MUL_S1,
        S_MUL_DEN,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic open_grp;
        logic close_grp;
        logic acc_a;
        logic acc_b;
        logic acc_c;
        logic acc_d;
        logic mul_ld_s2;
        logic mul_ld_s1;
        logic mul_ld_den;
        logic mul_step;
        logic div_ld;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_action;
        logic have_group;
        logic key_match;
        logic flush;
        logic few_samples;
        logic mul_done;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/gwv_if.sv @@
// request channels for records in and variance reports out
interface gwv_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [gwv_pkg::KEY_W-1:0]       group_key;
    logic [gwv_pkg::VAL_IN_W-1:0]    sample_value;
    logic [gwv_pkg::WEIGHT_W-1:0]    weight;

    modport source (output valid, action, group_key, sample_value, weight, input ready);
    modport sink   (input valid, action, group_key, sample_value, weight, output ready);
endinterface

interface gwv_out_if;
    logic                            valid;
    logic                            ready;
    logic [gwv_pkg::KEY_W-1:0]       out_key;
    logic [gwv_pkg::VAR_W-1:0]       variance;
    logic [gwv_pkg::CNT_OUT_W-1:0]   sample_count;
    logic [gwv_pkg::STATUS_W-1:0]    status;

    modport source (output valid, out_key, variance, sample_count, status, input ready);
    modport sink   (input valid, out_key, variance, sample_count, status, output ready);
endinterface

@@ hdl/gwv_datapath.sv @@
// accumulators, shift-add multiplier, restoring divider and output register
module gwv_datapath #(
    parameter int VALUE_BITS = 16,
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gwv_pkg::t_cmd                    i_cmd,
    output gwv_pkg::t_stat                   o_stat,
    input  logic                             i_action,
    input  logic [gwv_pkg::KEY_W-1:0]        i_group_key,
    input  logic [gwv_pkg::VAL_IN_W-1:0]     i_sample_value,
    input  logic [gwv_pkg::WEIGHT_W-1:0]     i_weight,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [gwv_pkg::KEY_W-1:0]        o_key,
    output logic [gwv_pkg::VAR_W-1:0]        o_variance,
    output logic [gwv_pkg::CNT_OUT_W-1:0]    o_count,
    output logic [gwv_pkg::STATUS_W-1:0]     o_status
);
    import gwv_pkg::*;

    localparam int V      = VALUE_BITS;
    localparam int C      = COUNT_BITS;
    localparam int RAW_W  = (V > VAL_IN_W) ? V : VAL_IN_W;
    localparam int CMP_W  = (C > WEIGHT_W) ? C : WEIGHT_W;
    localparam int SUM_W  = V + C;
    localparam int MAG_W  = V + C - 1;
    localparam int SQV_W  = 2 * V - 1;
    localparam int SQH_W  = (SQV_W + 1) / 2;
    localparam int SQU_W  = SQV_W - SQH_W;
    localparam int PRD_W  = C + SQH_W;
    localparam int SQ_W   = 2 * V + C - 2;
    localparam int PROD_W = 2 * V + 2 * C - 2;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int DEN_W  = 2 * C;
    localparam int DCNT_W = $clog2(NUM_W);
    localparam logic [C-1:0] CNT_MAX = '1;

    // captured request
    logic                    r_in_action;
    logic [KEY_W-1:0]        r_in_key;
    logic [V-1:0]            r_in_x;
    logic [WEIGHT_W-1:0]     r_in_w;

    // group state
    logic                    r_have;
    logic [KEY_W-1:0]        r_key;
    logic [C-1:0]            r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sumsq;
    logic                    r_ovf;

    // accumulate pipeline
    logic [C-1:0]            r_wc;
    logic [SQV_W-1:0]        r_sq;
    logic [PRD_W-1:0]        r_prod;
    logic signed [SUM_W-1:0] r_wx;

    // report arithmetic
    logic [PROD_W-1:0]       r_ma;
    logic [MAG_W-1:0]        r_mb;
    logic [PROD_W-1:0]       r_mp;
    logic [PROD_W-1:0]       r_a;
    logic [NUM_W-1:0]        r_num;
    logic [DEN_W-1:0]        r_den;
    logic [DEN_W-1:0]        r_rem;
    logic [VAR_W-1:0]        r_q;
    logic                    r_qsat;
    logic [DCNT_W-1:0]       r_dcnt;

    // output register
    logic                    r_out_valid;
    logic [KEY_W-1:0]        r_out_key;
    logic [VAR_W-1:0]        r_out_var;
    logic [CNT_OUT_W-1:0]    r_out_cnt;
    t_status                 r_out_status;

    logic [RAW_W-1:0]        raw_ext;
    logic [V-1:0]            x_mag;
    logic [2*V-1:0]          sq_full;
    logic [C-1:0]            room;
    logic [CMP_W-1:0]        w_ext;
    logic [CMP_W-1:0]        room_ext;
    logic                    w_over;
    logic [C-1:0]            wc;
    logic [PRD_W-1:0]        prod_lo;
    logic [C+SQU_W-1:0]      prod_hi;
    logic signed [C:0]       wc_s;
    logic signed [C+V:0]     wx_full;
    logic [SQ_W-1:0]         prod_ext;
    logic [SUM_W-1:0]        sum_bits;
    logic [SUM_W-1:0]        sum_abs;
    logic [MAG_W-1:0]        s_mag;
    logic [PROD_W-1:0]       dnum;
    logic [DEN_W:0]          rem_sh;
    logic [DEN_W:0]          rem_sub;
    logic                    q_bit;
    logic [CNT_OUT_W-1:0]    cnt_sat;
    logic [VAR_W-1:0]        var_res;
    logic                    out_free;

    assign raw_ext  = RAW_W'(i_sample_value);
    assign x_mag    = r_in_x[V-1] ? (~r_in_x + V'(1)) : r_in_x;
    assign sq_full  = x_mag * x_mag;
    assign room     = CNT_MAX - r_count;
    assign w_ext    = CMP_W'(r_in_w);
    assign room_ext = CMP_W'(room);
    assign w_over   = w_ext > room_ext;
    assign wc       = w_over ? room : w_ext[C-1:0];
    assign prod_lo  = r_wc * r_sq[SQH_W-1:0];
    assign prod_hi  = r_wc * r_sq[SQV_W-1:SQH_W];
    assign wc_s     = $signed({1'b0, r_wc});
    assign wx_full  = wc_s * $signed(r_in_x);
    assign prod_ext = SQ_W'(r_prod);
    assign sum_bits = r_sum;
    assign sum_abs  = sum_bits[SUM_W-1] ? (~sum_bits + SUM_W'(1)) : sum_bits;
    assign s_mag    = sum_abs[MAG_W-1:0];
    assign dnum     = (r_a >= r_mp) ? (r_a - r_mp) : '0;
    assign rem_sh   = {r_rem, r_num[NUM_W-1]};
    assign rem_sub  = rem_sh - {1'b0, r_den};
    assign q_bit    = rem_sh >= {1'b0, r_den};
    assign var_res  = r_qsat ? '1 : r_q;
    assign out_free = !r_out_valid || i_ready;

    generate
        if (C > CNT_OUT_W) begin : g_cnt_sat
            assign cnt_sat = (|r_count[C-1:CNT_OUT_W]) ? '1 : r_count[CNT_OUT_W-1:0];
        end else begin : g_cnt_ext
            assign cnt_sat = CNT_OUT_W'(r_count);
        end
    endgenerate

    always_comb begin
        o_stat.in_action   = i_action;
        o_stat.have_group  = r_have;
        o_stat.key_match   = (i_group_key == r_key);
        o_stat.flush       = r_in_action;
        o_stat.few_samples = !r_have || (r_count[C-1:1] == '0);
        o_stat.mul_done    = (r_mb == '0);
        o_stat.div_last    = (r_dcnt == '0);
        o_stat.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_action <= i_action;
            r_in_key    <= i_group_key;
            r_in_x      <= raw_ext[V-1:0];
            r_in_w      <= i_weight;
        end
    end

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_key   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_ovf   <= 1'b0;
        end else begin
            priority if (i_cmd.open_grp) begin
                r_have  <= 1'b1;
                r_key   <= r_in_key;
                r_count <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.close_grp) begin
                r_have <= 1'b0;
                r_key  <= '0;
            end else if (i_cmd.acc_a) begin
                r_count <= r_count + wc;
                r_ovf   <= r_ovf | w_over;
            end else if (i_cmd.acc_c) begin
                r_sumsq <= r_sumsq + prod_ext;
                r_sum   <= r_sum + r_wx;
            end else if (i_cmd.acc_d) begin
                r_sumsq <= r_sumsq + (prod_ext << SQH_W);
            end else begin
                r_have <= r_have;
            end
        end
    end

    // weight times value and weight times square, split in halves
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_a) begin
            r_wc <= wc;
            r_sq <= sq_full[SQV_W-1:0];
        end
        if (i_cmd.acc_b) begin
            r_prod <= prod_lo;
            r_wx   <= wx_full[SUM_W-1:0];
        end else if (i_cmd.acc_c) begin
            r_prod <= PRD_W'(prod_hi);
        end
    end

    // shift-add multiplier, one multiplier bit a cycle
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.mul_ld_s2) begin
            r_ma <= PROD_W'(r_sumsq);
            r_mb <= MAG_W'(r_count);
            r_mp <= '0;
        end else if (i_cmd.mul_ld_s1) begin
            r_a  <= r_mp;
            r_ma <= PROD_W'(s_mag);
            r_mb <= s_mag;
            r_mp <= '0;
        end else if (i_cmd.mul_ld_den) begin
            r_ma <= PROD_W'(r_count);
            r_mb <= MAG_W'(r_count - C'(1));
            r_mp <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mb[0]) begin
                r_mp <= r_mp + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end else begin
            r_mp <= r_mp;
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.mul_ld_den) begin
            r_num <= NUM_W'(dnum) << FRAC_BITS;
        end else if (i_cmd.div_ld) begin
            r_den  <= r_mp[DEN_W-1:0];
            r_rem  <= '0;
            r_q    <= '0;
            r_qsat <= 1'b0;
            r_dcnt <= DCNT_W'(NUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_num  <= r_num << 1;
            r_q    <= {r_q[VAR_W-2:0], q_bit};
            r_qsat <= r_qsat | r_q[VAR_W-1];
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end else begin
            r_dcnt <= r_dcnt;
        end
    end

    // report register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            priority if (!r_have) begin
                r_out_key    <= '0;
                r_out_var    <= '0;
                r_out_cnt    <= '0;
                r_out_status <= ST_NO_DATA;
            end else if (r_count == '0) begin
                r_out_key    <= r_key;
                r_out_var    <= '0;
                r_out_cnt    <= cnt_sat;
                r_out_status <= ST_NO_DATA;
            end else if (r_count == C'(1)) begin
                r_out_key    <= r_key;
                r_out_var    <= '0;
                r_out_cnt    <= cnt_sat;
                r_out_status <= r_ovf ? ST_SAT : ST_SINGLE;
            end else begin
                r_out_key    <= r_key;
                r_out_var    <= var_res;
                r_out_cnt    <= cnt_sat;
                r_out_status <= r_ovf ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_key      = r_out_key;
    assign o_variance = r_out_var;
    assign o_count    = r_out_cnt;
    assign o_status   = r_out_status;

endmodule

@@ hdl/gwv_ctrl.sv @@
// controller state machine sequencing accumulation and group reports
module gwv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  gwv_pkg::t_stat  i_stat,
    output gwv_pkg::t_cmd   o_cmd
);
    import gwv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    priority if (i_stat.in_action) begin
                        n_state = S_CHK;
                    end else if (!i_stat.have_group) begin
                        n_state = S_OPEN;
                    end else if (!i_stat.key_match) begin
                        n_state = S_CHK;
                    end else begin
                        n_state = S_ACC_A;
                    end
                end
            end
            S_OPEN: begin
                o_cmd.open_grp = 1'b1;
                n_state        = S_ACC_A;
            end
            S_ACC_A: begin
                o_cmd.acc_a = 1'b1;
                n_state     = S_ACC_B;
            end
            S_ACC_B: begin
                o_cmd.acc_b = 1'b1;
                n_state     = S_ACC_C;
            end
            S_ACC_C: begin
                o_cmd.acc_c = 1'b1;
                n_state     = S_ACC_D;
            end
            S_ACC_D: begin
                o_cmd.acc_d = 1'b1;
                n_state     = S_IDLE;
            end
            S_CHK: begin
                if (i_stat.few_samples) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.mul_ld_s2 = 1'b1;
                    n_state         = S_MUL_S2;
                end
            end
            S_MUL_S2: begin
                if (i_stat.mul_done) begin
                    o_cmd.mul_ld_s1 = 1'b1;
                    n_state         = S_MUL_S1;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_MUL_S1: begin
                if (i_stat.mul_done) begin
                    o_cmd.mul_ld_den = 1'b1;
                    n_state          = S_MUL_DEN;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_MUL_DEN: begin
                if (i_stat.mul_done) begin
                    o_cmd.div_ld = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.flush) begin
                        o_cmd.close_grp = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_OPEN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/grouped_weighted_variance.sv @@
// top level of the grouped weighted variance block
// Records must arrive sorted by group key, which the block does not enforce, and are accepted
// one at a time: a record that stays in the open group is accepted and then passes four
// accumulate steps, set by the weight times square product being formed in two halves; one that
// opens a group passes an open step first. A record with a new key, or a flush, first reports the
// finished group: for groups of two or more samples a shared shift-add multiplier forms n*S2,
// S1*S1 and n*(n-1) one multiplier bit a cycle, each product ending once the remaining multiplier
// bits are zero, then a restoring divider divides n*S2-S1*S1, scaled by 2^FRAC_BITS, by n*(n-1).
// Groups of fewer than two samples skip the multiplier and divider. The report sits in an output
// register, so the next record is taken while it waits; a further report stalls only until
// that register is free.
module grouped_weighted_variance #(
    parameter int VALUE_BITS = 16,
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gwv_in_if.sink     i_in,
    gwv_out_if.source  o_out
);
    import gwv_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    gwv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gwv_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (i_in.action),
        .i_group_key    (i_in.group_key),
        .i_sample_value (i_in.sample_value),
        .i_weight       (i_in.weight),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_key          (o_out.out_key),
        .o_variance     (o_out.variance),
        .o_count        (o_out.sample_count),
        .o_status       (o_out.status)
    );

endmodule

@@ hdl/gwv_checker.sv @@
// port-level assertions for the grouped weighted variance block and their binding
module gwv_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [gwv_pkg::KEY_W-1:0]        i_out_key,
    input  logic [gwv_pkg::VAR_W-1:0]        i_out_variance,
    input  logic [gwv_pkg::CNT_OUT_W-1:0]    i_out_count,
    input  logic [gwv_pkg::STATUS_W-1:0]     i_out_status
);
    import gwv_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("report dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_key) && $stable(i_out_variance)
            && $stable(i_out_count) && $stable(i_out_status))
        else $error("stalled report changed");

    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_NO_DATA |-> i_out_variance == '0)
        else $error("empty group reports nonzero variance");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_SINGLE
            |-> i_out_variance == '0 && i_out_count == CNT_OUT_W'(1))
        else $error("single sample group reported wrongly");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one still in work");

endmodule

bind grouped_weighted_variance gwv_checker u_gwv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_key      (o_out.out_key),
    .i_out_variance (o_out.variance),
    .i_out_count    (o_out.sample_count),
    .i_out_status   (o_out.status)
);
